@@ design/cmdtok_pkg.sv @@
// ============================================================================
// cmdtok_pkg
// Shared types, token codes and the keyword table of the command line
// tokenizer.
// ============================================================================
`default_nettype none

package cmdtok_pkg;

	// Default keyword length limit
	localparam int KEYWORD_LEN_DEF = 4;

	// Result queue depth (power of two)
	localparam int OUTQ_DEPTH = 4;

	// Token type codes
	localparam logic [4:0] T_ERROR   = 5'd0;
	localparam logic [4:0] T_NEWLINE = 5'd1;
	localparam logic [4:0] T_NUMBER  = 5'd2;
	localparam logic [4:0] T_STRING  = 5'd3;
	localparam logic [4:0] T_KW_BASE = 5'd4;

	// Result kinds
	localparam logic RK_VALUE = 1'b0;
	localparam logic RK_CLOSE = 1'b1;

	// Keyword table, bytes packed big-endian into the low bytes
	localparam int NUM_KEYWORDS = 15;

	localparam logic [31:0] KW_TEXT [NUM_KEYWORDS] = '{
		32'h4558_4543, // EXEC
		32'h5041_5353, // PASS
		32'h0044_454C, // DEL
		32'h5049_4E47, // PING
		32'h5354_4F50, // STOP
		32'h0053_4554, // SET
		32'h0047_4554, // GET
		32'h484F_5354, // HOST
		32'h5343_4844, // SCHD
		32'h5052_494F, // PRIO
		32'h4445_4C56, // DELV
		32'h4445_4C47, // DELG
		32'h4445_4C53, // DELS
		32'h4745_544B, // GETK
		32'h4348_4B47  // CHKG
	};

	localparam logic [2:0] KW_LEN [NUM_KEYWORDS] = '{
		3'd4, 3'd4, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd4,
		3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4
	};

	// One result beat
	typedef struct packed {
		logic       kind;
		logic [7:0] value;
		logic [4:0] ttype;
		logic       last;
	} result_t;

	// Up to two results caused by one input byte
	typedef struct packed {
		logic [1:0] cnt;
		result_t    first;
		result_t    second;
	} res_pair_t;

	// Keyword lookup; first table match wins, no match is a string
	function automatic logic [4:0] keyword_code(input logic [31:0] prefix,
			input logic [2:0] len);
		logic [4:0] code;
		code = T_STRING;
		for (int i = NUM_KEYWORDS - 1; i >= 0; i--) begin
			if (KW_LEN[i] == len && KW_TEXT[i] == prefix)
				code = T_KW_BASE + 5'(i);
		end
		return code;
	endfunction

endpackage

`default_nettype wire

@@ design/cmdtok_lexer.sv @@
// ============================================================================
// cmdtok_lexer
// Lexer state machine: classifies one byte against the current mode and
// produces zero, one or two results in the same cycle.
// ============================================================================
`default_nettype none

module cmdtok_lexer
	import cmdtok_pkg::*;
#(
	parameter int KEYWORD_LEN = KEYWORD_LEN_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire logic [7:0] in_byte,
	output res_pair_t       res
);

	localparam int LenW = $clog2(KEYWORD_LEN + 2);

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [5:0] {
		MODE_IDLE = 6'b000001,
		MODE_SKIP = 6'b000010,
		MODE_NUM  = 6'b000100,
		MODE_STR  = 6'b001000,
		MODE_ESC  = 6'b010000,
		MODE_WORD = 6'b100000
	} mode_t;

	mode_t             mode_q, mode_d;
	logic [31:0]       prefix_q, prefix_d;
	logic [LenW-1:0]   len_q, len_d;

	logic              is_ctrl, is_digit, is_blank;
	mode_t             s_mode;
	logic              s_emit, s_word;
	result_t           s_res;
	logic              do_close, do_start, do_value;
	logic [4:0]        close_type;
	logic [4:0]        word_code;

	function automatic result_t mk_value(input logic [7:0] c);
		result_t r;
		r       = '0;
		r.kind  = RK_VALUE;
		r.value = c;
		return r;
	endfunction

	function automatic result_t mk_close(input logic [4:0] t);
		result_t r;
		r       = '0;
		r.kind  = RK_CLOSE;
		r.ttype = t;
		return r;
	endfunction

	// Byte classes
	assign is_ctrl  = (in_byte < CH_SPACE) || (in_byte == CH_DEL);
	assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
	assign is_blank = (in_byte == CH_SPACE) || (in_byte == CH_TAB) || (in_byte == CH_VT)
		|| (in_byte == CH_FF) || (in_byte == CH_CR);

	// Type of the bare word collected so far
	assign word_code = (len_q > LenW'(4)) ? T_STRING : keyword_code(prefix_q, len_q[2:0]);

	// Token start decode
	always_comb begin
		s_mode = MODE_IDLE;
		s_emit = 1'b0;
		s_word = 1'b0;
		s_res  = '0;
		if (in_byte == CH_LF) begin
			s_emit = 1'b1;
			s_res  = mk_close(T_NEWLINE);
		end else if (is_ctrl) begin
			s_emit = 1'b1;
			s_res  = mk_close(T_ERROR);
		end else if (in_byte == CH_SPACE) begin
			s_mode = MODE_SKIP;
		end else if (is_digit) begin
			s_emit = 1'b1;
			s_res  = mk_value(in_byte);
			s_mode = MODE_NUM;
		end else if (in_byte == CH_QUOTE) begin
			s_mode = MODE_STR;
		end else begin
			s_emit = 1'b1;
			s_word = 1'b1;
			s_res  = mk_value(in_byte);
			s_mode = MODE_WORD;
		end
	end

	// Mode decode
	always_comb begin
		do_close   = 1'b0;
		do_start   = 1'b0;
		do_value   = 1'b0;
		close_type = T_ERROR;
		mode_d     = mode_q;
		prefix_d   = prefix_q;
		len_d      = len_q;
		unique case (mode_q)
			MODE_SKIP: begin
				if (!is_blank)
					do_start = 1'b1;
			end
			MODE_NUM: begin
				if (is_digit) begin
					do_value = 1'b1;
				end else begin
					do_close   = 1'b1;
					close_type = T_NUMBER;
					do_start   = 1'b1;
				end
			end
			MODE_STR: begin
				if (in_byte == CH_QUOTE) begin
					do_close   = 1'b1;
					close_type = T_STRING;
					mode_d     = MODE_IDLE;
				end else if (is_ctrl) begin
					do_close   = 1'b1;
					close_type = T_ERROR;
					mode_d     = MODE_IDLE;
				end else if (in_byte == CH_BSL) begin
					mode_d = MODE_ESC;
				end else begin
					do_value = 1'b1;
				end
			end
			MODE_ESC: begin
				do_value = 1'b1;
				mode_d   = MODE_STR;
			end
			MODE_WORD: begin
				if (in_byte != CH_SPACE && !is_ctrl) begin
					do_value = 1'b1;
					if (len_q < LenW'(4))
						prefix_d = {prefix_q[23:0], in_byte};
					if (len_q < LenW'(KEYWORD_LEN + 1))
						len_d = len_q + LenW'(1);
				end else begin
					do_close   = 1'b1;
					close_type = word_code;
					do_start   = 1'b1;
				end
			end
			default: begin
				do_start = 1'b1;
			end
		endcase

		if (do_start) begin
			mode_d = s_mode;
			if (s_word) begin
				prefix_d = {24'h0, in_byte};
				len_d    = LenW'(1);
			end
		end
	end

	// Result composition; last marks the final beat of this byte
	always_comb begin
		res = '0;
		if (do_close) begin
			res.first = mk_close(close_type);
			if (do_start && s_emit) begin
				res.second = s_res;
				res.cnt    = 2'd2;
			end else begin
				res.cnt = 2'd1;
			end
		end else if (do_start) begin
			res.first = s_res;
			res.cnt   = {1'b0, s_emit};
		end else if (do_value) begin
			res.first = mk_value(in_byte);
			res.cnt   = 2'd1;
		end
		res.first.last  = (res.cnt == 2'd1);
		res.second.last = (res.cnt == 2'd2);
	end

	// Lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			prefix_q <= '0;
			len_q    <= '0;
		end else if (fire) begin
			mode_q   <= mode_d;
			prefix_q <= prefix_d;
			len_q    <= len_d;
		end
	end

endmodule

`default_nettype wire

@@ design/cmdtok_outq.sv @@
// ============================================================================
// cmdtok_outq
// Small result queue: takes up to two beats per cycle, hands out one per cycle when popped.
// ============================================================================
`default_nettype none

module cmdtok_outq
	import cmdtok_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire res_pair_t push,
	input  wire logic      push_en,
	output logic           room,
	output logic           out_valid,
	input  wire logic      out_pop,
	output result_t        out_data
);

	localparam int AW = $clog2(OUTQ_DEPTH);
	localparam int CW = $clog2(OUTQ_DEPTH + 1);

	result_t         mem_q [OUTQ_DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic [1:0]      push_cnt;
	logic            pop;

	assign push_cnt  = push_en ? push.cnt : 2'd0;
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_pop;
	assign out_data  = mem_q[rd_ptr_q];
	assign room      = (count_q <= CW'(OUTQ_DEPTH - 2));

	// Entry storage
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0)
			mem_q[wr_ptr_q] <= push.first;
		if (push_cnt == 2'd2)
			mem_q[wr_ptr_q + AW'(1)] <= push.second;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + AW'(push_cnt);
			if (pop)
				rd_ptr_q <= rd_ptr_q + AW'(1);
			count_q <= count_q + CW'(push_cnt) - CW'(pop);
		end
	end

endmodule

`default_nettype wire

@@ design/command_line_tokenizer_core.sv @@
// ============================================================================
// command_line_tokenizer_core
// Byte-wide command line tokenizer with streamed token values.
// ============================================================================
// Takes one byte per cycle while in_stall is low and splits the stream into
// newline, error, number, string and keyword tokens. Value bytes leave as
// they arrive; each token is closed by a beat carrying its type, and
// last_of_run marks the final beat caused by an input byte. Each accepted
// byte steps the lexer and may cause zero, one or two result beats, which go
// through a four-entry result queue. The output port moves one beat per cycle
// while out_stall is low, so in_stall rises whenever the queue cannot take two
// more beats; with at most one beat per byte on average and no receiver stall the block sustains one byte per cycle.
// ============================================================================
`default_nettype none

module command_line_tokenizer_core
	import cmdtok_pkg::*;
#(
	parameter int KEYWORD_LEN = KEYWORD_LEN_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            result_kind,
	output logic [7:0]      value_byte,
	output logic [4:0]      token_type,
	output logic            last_of_run
);

	res_pair_t res;
	result_t   head;
	logic      room;
	logic      fire;

	// Input beat handshake
	assign in_stall = !room;
	assign fire     = in_valid && room;

	cmdtok_lexer #(
		.KEYWORD_LEN(KEYWORD_LEN)
	) u_lexer (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.in_byte (in_byte),
		.res     (res)
	);

	cmdtok_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res),
		.push_en   (fire),
		.room      (room),
		.out_valid (out_valid),
		.out_pop   (!out_stall),
		.out_data  (head)
	);

	// Output beat fields
	assign result_kind = head.kind;
	assign value_byte  = head.value;
	assign token_type  = head.ttype;
	assign last_of_run = head.last;

endmodule

`default_nettype wire

@@ sim/tokenizer_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tokenizer_checker
// Watches both channels of the command line tokenizer, predicts the result
// beats of every accepted input byte and compares each delivered beat with
// the oldest prediction still waiting.
// ============================================================================
`default_nettype none

module tokenizer_checker
	import cmdtok_pkg::*;
#(
	parameter int KEYWORD_LEN = KEYWORD_LEN_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       out_valid,
	input  wire logic       out_stall,
	input  wire logic       result_kind,
	input  wire logic [7:0] value_byte,
	input  wire logic [4:0] token_type,
	input  wire logic       last_of_run,
	output int              fail_count,
	output int              pending_count
);

	// Byte classes used by the lexer
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DEL    = 8'h7F;
	localparam logic [4:0] TT_NONE   = 5'd0;
	localparam int         MAX_REPORTS = 10;

	typedef enum logic [2:0] {
		LX_IDLE = 3'd0,
		LX_SKIP = 3'd1,
		LX_NUM  = 3'd2,
		LX_STR  = 3'd3,
		LX_ESC  = 3'd4,
		LX_WORD = 3'd5
	} lex_mode_e;

	// Predicted lexer state
	lex_mode_e   lex_st;
	logic [31:0] word_bytes;
	logic [2:0]  word_len;

	result_t byte_beats[$];     // beats caused by the byte being predicted
	result_t expected_beats[$]; // beats still owed by the block
	result_t head_beat;
	int      mismatches;

	function automatic logic is_ctrl(input logic [7:0] c);
		return c < 8'd32 || c == CH_DEL;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function void add_beat(input logic kind, input logic [7:0] val, input logic [4:0] tt);
		result_t r;
		r.kind  = kind;
		r.value = val;
		r.ttype = tt;
		r.last  = 1'b0;
		byte_beats.push_back(r);
	endfunction

	// First four bytes are kept, length saturates one past the keyword limit
	function void grow_word(input logic [7:0] c);
		if (word_len < 3'd4)
			word_bytes = {word_bytes[23:0], c};
		if (word_len < KEYWORD_LEN + 1)
			word_len = word_len + 3'd1;
	endfunction

	// Keyword table in order, first hit wins; anything else is a string
	function logic [4:0] word_code();
		if (word_len > KEYWORD_LEN || word_len > 3'd4)
			return T_STRING;
		for (int i = 0; i < NUM_KEYWORDS; i++) begin
			if (KW_LEN[i] == word_len && KW_TEXT[i] == word_bytes)
				return T_KW_BASE + 5'(i);
		end
		return T_STRING;
	endfunction

	function void start_token(input logic [7:0] c);
		lex_st = LX_IDLE;
		if (c == CH_NL) begin
			add_beat(RK_CLOSE, 8'h00, T_NEWLINE);
		end else if (is_ctrl(c)) begin
			add_beat(RK_CLOSE, 8'h00, T_ERROR);
		end else if (c == CH_SPACE) begin
			lex_st = LX_SKIP;
		end else if (is_digit(c)) begin
			add_beat(RK_VALUE, c, TT_NONE);
			lex_st = LX_NUM;
		end else if (c == CH_QUOTE) begin
			lex_st = LX_STR;
		end else begin
			word_bytes = '0;
			word_len   = '0;
			grow_word(c);
			add_beat(RK_VALUE, c, TT_NONE);
			lex_st = LX_WORD;
		end
	endfunction

	// Advance the predicted lexer by one byte and queue the beats it owes
	function void tokenize_byte(input logic [7:0] c);
		byte_beats.delete();
		case (lex_st)
			LX_SKIP: begin
				if (!(c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR))
					start_token(c);
			end
			LX_NUM: begin
				if (is_digit(c)) begin
					add_beat(RK_VALUE, c, TT_NONE);
				end else begin
					add_beat(RK_CLOSE, 8'h00, T_NUMBER);
					start_token(c);
				end
			end
			LX_STR: begin
				if (c == CH_QUOTE) begin
					add_beat(RK_CLOSE, 8'h00, T_STRING);
					lex_st = LX_IDLE;
				end else if (is_ctrl(c)) begin
					add_beat(RK_CLOSE, 8'h00, T_ERROR);
					lex_st = LX_IDLE;
				end else if (c == CH_BSLASH) begin
					lex_st = LX_ESC;
				end else begin
					add_beat(RK_VALUE, c, TT_NONE);
				end
			end
			LX_ESC: begin
				add_beat(RK_VALUE, c, TT_NONE);
				lex_st = LX_STR;
			end
			LX_WORD: begin
				if (c != CH_SPACE && !is_ctrl(c)) begin
					grow_word(c);
					add_beat(RK_VALUE, c, TT_NONE);
				end else begin
					add_beat(RK_CLOSE, 8'h00, word_code());
					start_token(c);
				end
			end
			default: start_token(c);
		endcase
		if (byte_beats.size() > 0)
			byte_beats[byte_beats.size() - 1].last = 1'b1;
		foreach (byte_beats[i])
			expected_beats.push_back(byte_beats[i]);
	endfunction

	// Input beats feed the prediction, output beats are checked in order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lex_st        = LX_IDLE;
			word_bytes    = '0;
			word_len      = '0;
			mismatches    = 0;
			expected_beats.delete();
			fail_count    <= 0;
			pending_count <= 0;
		end else begin
			if (in_valid && !in_stall)
				tokenize_byte(in_byte);
			if (out_valid && !out_stall) begin
				if (expected_beats.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: unexpected beat kind=%0d value=%02h type=%0d last=%0d",
							$time, result_kind, value_byte, token_type, last_of_run);
				end else begin
					head_beat = expected_beats.pop_front();
					if (head_beat.kind !== result_kind || head_beat.value !== value_byte ||
							head_beat.ttype !== token_type || head_beat.last !== last_of_run) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("%0t: beat mismatch, expected kind=%0d value=%02h type=%0d last=%0d, got kind=%0d value=%02h type=%0d last=%0d",
								$time, head_beat.kind, head_beat.value, head_beat.ttype,
								head_beat.last, result_kind, value_byte, token_type,
								last_of_run);
					end
				end
			end
			fail_count    <= mismatches;
			pending_count <= expected_beats.size();
		end
	end

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Stimulus and verdict for the command line tokenizer.
// ============================================================================
// Sends a short directed byte sequence, then random command lines built from
// keywords, near-miss words, numbers, quoted strings with escapes, newlines,
// whitespace runs and raw noise bytes. Three pacing phases vary sender gaps
// and receiver stalls. The checker beside the block predicts and compares.
// ============================================================================
`default_nettype none

module tb_top;
	import cmdtok_pkg::*;

	localparam int         RANDOM_BYTES = 1700;
	localparam int         IDLE_LIMIT   = 2000;
	localparam int         DRAIN_CYCLES = 20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DEL    = 8'h7F;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic [7:0] in_byte   = 8'h00;
	logic       out_stall = 1'b0;
	logic       in_stall;
	logic       out_valid;
	logic       result_kind;
	logic [7:0] value_byte;
	logic [4:0] token_type;
	logic       last_of_run;
	int         fail_count;
	int         pending_count;

	int         idle_pct  = 22;
	int         stall_pct = 77;
	int         quiet_cycles = 0;
	logic [7:0] stim_bytes[$];

	command_line_tokenizer_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.value_byte  (value_byte),
		.token_type  (token_type),
		.last_of_run (last_of_run)
	);

	tokenizer_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_byte       (in_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_kind   (result_kind),
		.value_byte    (value_byte),
		.token_type    (token_type),
		.last_of_run   (last_of_run),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Receiver backpressure
	always @(posedge clk)
		out_stall <= arst_n && ($urandom_range(99) < stall_pct);

	// Watchdog: too long without any beat moving ends the run
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			stim_bytes.push_back(s[i]);
	endfunction

	// Ordinary byte for a bare word: mostly capitals, some of everything else
	function logic [7:0] word_char();
		case ($urandom_range(9))
			6:       return 8'("a") + 8'($urandom_range(25));
			7:       return $urandom_range(1) ? CH_QUOTE : 8'("0") + 8'($urandom_range(9));
			8:       return 8'($urandom_range(126, 33));
			9:       return 8'($urandom_range(255, 128));
			default: return 8'("A") + 8'($urandom_range(25));
		endcase
	endfunction

	function logic [7:0] ctrl_byte();
		return $urandom_range(15) == 0 ? CH_DEL : 8'($urandom_range(31));
	endfunction

	// Keyword, possibly grown, cut short or altered
	function void add_keyword();
		int         idx;
		int         n;
		logic [7:0] w[$];
		idx = $urandom_range(NUM_KEYWORDS - 1);
		n   = KW_LEN[idx];
		for (int k = n - 1; k >= 0; k--)
			w.push_back(KW_TEXT[idx][8 * k +: 8]);
		case ($urandom_range(7))
			0: w.push_back(word_char());
			1: void'(w.pop_back());
			2: w[$urandom_range(n - 1, 1)] = 8'("A") + 8'($urandom_range(25));
			default: ;
		endcase
		foreach (w[i])
			stim_bytes.push_back(w[i]);
	endfunction

	function void add_word();
		int         n;
		logic [7:0] c;
		n = $urandom_range(3) == 0 ? $urandom_range(9, 1) : $urandom_range(5, 1);
		c = word_char();
		if (c == CH_QUOTE || (c >= "0" && c <= "9"))
			c = 8'("Q");
		stim_bytes.push_back(c);
		for (int i = 1; i < n; i++) begin
			c = word_char();
			stim_bytes.push_back(c);
		end
	endfunction

	// Quoted string with escapes; now and then cut off by a control byte
	function void add_quoted();
		int         n;
		logic [7:0] c;
		n = $urandom_range(6);
		stim_bytes.push_back(CH_QUOTE);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(4) == 0) begin
				stim_bytes.push_back(CH_BSLASH);
				stim_bytes.push_back(8'($urandom_range(255)));
			end else begin
				c = $urandom_range(3) == 0 ? 8'($urandom_range(255, 128))
					: 8'($urandom_range(126, 32));
				if (c == CH_QUOTE || c == CH_BSLASH)
					c = 8'("s");
				stim_bytes.push_back(c);
			end
		end
		stim_bytes.push_back($urandom_range(9) == 0 ? ctrl_byte() : CH_QUOTE);
	endfunction

	function void add_separator();
		int         r;
		logic [7:0] ws[5];
		ws = '{CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};
		r  = $urandom_range(9);
		if (r <= 5) begin
			stim_bytes.push_back(CH_SPACE);
		end else if (r == 6) begin
			stim_bytes.push_back(CH_SPACE);
			for (int i = $urandom_range(3); i > 0; i--)
				stim_bytes.push_back(ws[$urandom_range(4)]);
		end
	endfunction

	function void add_random_token();
		int r;
		r = $urandom_range(99);
		if (r < 25)
			add_keyword();
		else if (r < 40)
			add_word();
		else if (r < 55)
			for (int i = $urandom_range(5, 1); i > 0; i--)
				stim_bytes.push_back(8'("0") + 8'($urandom_range(9)));
		else if (r < 70)
			add_quoted();
		else if (r < 80)
			stim_bytes.push_back(CH_NL);
		else if (r < 90)
			stim_bytes.push_back(8'($urandom_range(255)));
		else
			stim_bytes.push_back(ctrl_byte());
		add_separator();
	endfunction

	// One input beat; payload holds until accepted
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	initial begin
		int total;

		// Directed: byte extremes, skip repair, number ended by a word,
		// escaped control byte, control byte inside a string, keyword
		stim_bytes.push_back(8'h00);
		stim_bytes.push_back(CH_DEL);
		stim_bytes.push_back(CH_NL);
		stim_bytes.push_back(CH_SPACE);
		stim_bytes.push_back(CH_TAB);
		stim_bytes.push_back(CH_CR);
		stim_bytes.push_back(CH_NL);
		add_text("09x");
		stim_bytes.push_back(8'hFF);
		stim_bytes.push_back(CH_SPACE);
		stim_bytes.push_back(CH_QUOTE);
		stim_bytes.push_back(CH_BSLASH);
		stim_bytes.push_back(8'h01);
		stim_bytes.push_back(CH_QUOTE);
		stim_bytes.push_back(CH_QUOTE);
		add_text("a");
		stim_bytes.push_back(8'h02);
		add_text("GET");
		stim_bytes.push_back(CH_SPACE);
		stim_bytes.push_back(8'h05);

		total = stim_bytes.size() + RANDOM_BYTES;
		while (stim_bytes.size() < total)
			add_random_token();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Three pacing phases: slow receiver, slow sender, full rate
		for (int i = 0; i < stim_bytes.size(); i++) begin
			if (i == stim_bytes.size() / 3) begin
				idle_pct  = 77;
				stall_pct <= 22;
			end else if (i == 2 * stim_bytes.size() / 3) begin
				idle_pct  = 0;
				stall_pct <= 0;
			end
			send_byte(stim_bytes[i]);
		end
		in_valid <= 1'b0;

		// Drain, then let any stray beat show up
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
design/cmdtok_pkg.sv
design/cmdtok_lexer.sv
design/cmdtok_outq.sv
design/command_line_tokenizer_core.sv
sim/tokenizer_checker.sv
sim/tb_top.sv
